FILE: src/rsa_pkg.sv
package rsa_pkg;

   // operand widths
   localparam int MOD_BITS  = 32;
   localparam int WORD_BITS = 32;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PUBLIC_EXP  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PRIVATE_EXP = CSR_IDX_W'(2);

   // operation kinds
   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [WORD_BITS-1:0] value;
      logic                 last;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] result_value;
      logic                 result_last;
   } rsp_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_REDUCE = 5'b00010,
      S_MUL    = 5'b00100,
      S_SQR    = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

endpackage

FILE: src/rsa_modmul.sv
module rsa_modmul
   import rsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] op_a,
   input  logic [MOD_BITS-1:0]  op_b,
   input  logic [MOD_BITS-1:0]  modulus,
   output logic                 done,
   output logic [MOD_BITS-1:0]  result
);

   localparam int CNT_W = $clog2(WORD_BITS);
   localparam int DW    = MOD_BITS + 3;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [MOD_BITS-1:0]  r_ff, r_in;

   logic [DW-1:0] sum;
   logic [DW-1:0] diff1;
   logic [DW-1:0] diff2;
   logic [MOD_BITS-1:0] r_step;

   // one multiplier bit per cycle: r = 2r + bit*b, then reduce below m
   always_comb begin
      sum   = (DW'(r_ff) << 1) + (a_ff[WORD_BITS-1] ? DW'(op_b) : '0);
      diff1 = sum - DW'(modulus);
      diff2 = sum - (DW'(modulus) << 1);
      if (!diff2[DW-1]) begin
         r_step = diff2[MOD_BITS-1:0];
      end else if (!diff1[DW-1]) begin
         r_step = diff1[MOD_BITS-1:0];
      end else begin
         r_step = sum[MOD_BITS-1:0];
      end
   end

   // bit counter and shift control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WORD_BITS - 1);
         a_in    = op_a;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = r_step;
         a_in   = a_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      r_ff   <= r_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

`ifndef ASSERT_OFF
   a_partial_reduced: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |-> r_ff < modulus)
      else $error("partial product not reduced below modulus");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done raised while still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("start did not begin a multiply");
`endif

endmodule

FILE: src/rsa_modexp_cipher.sv
// Textbook RSA: each request beat returns value^e mod n, with e the public exponent for
// kind 0 and the private exponent for kind 1; last is copied to the response. One bit-serial
// modular multiplier does all the work, one multiplier bit per cycle. An item spends one
// multiply reducing value mod n, then for each exponent bit up to its highest set bit a
// squaring (skipped after the top bit) and, where the bit is set, a multiply. A zero
// exponent still spends the reducing multiply; a modulus below two skips the multiplier
// and answers zero.
// One item is worked at a time; a new request is taken as soon as the finished result has
// moved to the response register, even while that response is still stalled.
module rsa_modexp_cipher
   import rsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_BITS-1:0] csr_wdata
);

   logic [WORD_BITS-1:0] modulus_ff;
   logic [WORD_BITS-1:0] pub_exp_ff;
   logic [WORD_BITS-1:0] priv_exp_ff;

   state_type            state_ff, state_in;
   logic                 start_ff, start_in;
   logic [WORD_BITS-1:0] value_ff, value_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;
   logic                 last_ff, last_in;
   logic [MOD_BITS-1:0]  acc_ff, acc_in;
   logic [MOD_BITS-1:0]  base_ff, base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [MOD_BITS-1:0]  mod_used;
   logic                 req_take;
   logic                 rsp_free;
   logic [WORD_BITS-1:0] mul_a;
   logic [MOD_BITS-1:0]  mul_b;
   logic                 mul_done;
   logic [MOD_BITS-1:0]  mul_res;
   logic [WORD_BITS-1:0] exp_next;

   assign mod_used = modulus_ff[MOD_BITS-1:0];
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign exp_next = exp_ff >> 1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= WORD_BITS'(3233);
         pub_exp_ff  <= WORD_BITS'(17);
         priv_exp_ff <= WORD_BITS'(2753);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_MODULUS:     modulus_ff  <= csr_wdata;
            CSR_PUBLIC_EXP:  pub_exp_ff  <= csr_wdata;
            CSR_PRIVATE_EXP: priv_exp_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = WORD_BITS'(base_ff);
      mul_b = base_ff;
      case (state_ff)
         S_REDUCE: begin
            mul_a = value_ff;
            mul_b = MOD_BITS'(1);
         end
         S_MUL: begin
            mul_a = WORD_BITS'(acc_ff);
         end
         default: ;
      endcase
   end

   rsa_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (mod_used),
      .done    (mul_done),
      .result  (mul_res)
   );

   // square-and-multiply sequencer, exponent scanned lsb first
   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      value_in     = value_ff;
      exp_in       = exp_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               value_in = req_data.value;
               last_in  = req_data.last;
               exp_in   = (req_data.kind == KIND_DECRYPT) ? priv_exp_ff : pub_exp_ff;
               if (mod_used < MOD_BITS'(2)) begin
                  acc_in   = '0;
                  state_in = S_DONE;
               end else begin
                  acc_in   = MOD_BITS'(1);
                  start_in = 1'b1;
                  state_in = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (mul_done) begin
               base_in = mul_res;
               if (exp_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  start_in = 1'b1;
                  state_in = exp_ff[0] ? S_MUL : S_SQR;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               acc_in = mul_res;
               if (exp_next == '0) begin
                  state_in = S_DONE;
               end else begin
                  start_in = 1'b1;
                  state_in = S_SQR;
               end
            end
         end
         S_SQR: begin
            if (mul_done) begin
               base_in  = mul_res;
               exp_in   = exp_next;
               start_in = 1'b1;
               state_in = exp_next[0] ? S_MUL : S_SQR;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = WORD_BITS'(acc_ff);
               rsp_in.result_last  = last_ff;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff <= value_in;
      exp_ff   <= exp_in;
      last_ff  <= last_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_done_in_work: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_REDUCE) || (state_ff == S_MUL) || (state_ff == S_SQR))
      else $error("multiply finished outside a working state");

   a_base_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) || (state_ff == S_SQR) |-> base_ff < mod_used && acc_ff < mod_used)
      else $error("operand not reduced below modulus");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != S_IDLE)
      else $error("accepted beat did not start work");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import rsa_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);
   localparam logic [63:0] MOD_MASK      = (64'd1 << MOD_BITS) - 64'd1;
   localparam int          WATCHDOG_LIMIT = 25000;
   localparam int          HOLD_OFF       = 3000;
   localparam int          END_WAIT       = 2500;
   localparam int          PHASE_ITEMS    = 30;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wen   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_BITS-1:0] csr_wdata = '0;

   // shadow copy of the key registers
   logic [WORD_BITS-1:0] key_modulus;
   logic [WORD_BITS-1:0] key_public;
   logic [WORD_BITS-1:0] key_private;

   // results still owed by the block, oldest first
   rsp_type pending_cipher[$];
   int      fail_count = 0;

   // sender burst control
   int burst_left = 0;
   int gap_max    = 0;

   // receiver stall control
   int   stall_pct    = 0;
   int   hold_request = 0;
   int   hold_left    = 0;
   int   run_left     = 0;
   logic run_stall    = 1'b0;

   rsa_modexp_cipher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // value^exponent mod modulus, square and multiply on 64-bit words
   function automatic logic [WORD_BITS-1:0] modexp(input logic [WORD_BITS-1:0] base,
                                                   input logic [WORD_BITS-1:0] exponent,
                                                   input logic [WORD_BITS-1:0] modulus);
      logic [63:0]          m;
      logic [63:0]          acc;
      logic [63:0]          sq;
      logic [WORD_BITS-1:0] e;
      m = {32'b0, modulus} & MOD_MASK;
      if (m < 64'd2) return '0;
      acc = 64'd1;
      sq  = {32'b0, base} % m;
      e   = exponent;
      while (e != '0) begin
         if (e[0]) acc = (acc * sq) % m;
         sq = (sq * sq) % m;
         e  = e >> 1;
      end
      return acc[WORD_BITS-1:0];
   endfunction

   function automatic rsp_type cipher_of(input req_type item);
      rsp_type r;
      r.result_value = modexp(item.value,
                              (item.kind == KIND_DECRYPT) ? key_private : key_public,
                              key_modulus);
      r.result_last  = item.last;
      return r;
   endfunction

   task automatic note_failure(input string detail);
      fail_count++;
      if (fail_count <= 10) $display("%0t %s", $realtime, detail);
   endtask

   // one request beat, with a random gap before each burst when gap_max is set
   task automatic send_item(input logic kind, input logic [WORD_BITS-1:0] value,
                            input logic last);
      req_type beat;
      beat.kind  = kind;
      beat.value = value;
      beat.last  = last;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         if (gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_cipher.push_back(cipher_of(beat));
   endtask

   // stop offering and wait until every owed result is back
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_cipher.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_key(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_BITS-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_MODULUS:     key_modulus = data;
         CSR_PUBLIC_EXP:  key_public  = data;
         CSR_PRIVATE_EXP: key_private = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] pick_value(input logic [WORD_BITS-1:0] m);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return m - 1;
         3:       return m;
         4, 5, 6: return (m == '0) ? $urandom : $urandom_range(0, m - 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_exponent(input bit full);
      if (full) return $urandom;
      return $urandom & ((32'd1 << $urandom_range(0, 10)) - 32'd1);
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_modulus();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(2, 255);
         1:       return $urandom_range(256, 65535);
         2:       return $urandom | 32'd1;
         3:       return $urandom;
         4:       return '1;
         default: return $urandom_range(0, 1);
      endcase
   endfunction

   // reset keys: round trip of one character plus the value extremes
   task automatic test_reset_keys();
      send_item(KIND_ENCRYPT, 32'd65, 1'b0);
      send_item(KIND_DECRYPT, 32'd2790, 1'b1);
      send_item(KIND_ENCRYPT, 32'd0, 1'b0);
      send_item(KIND_ENCRYPT, 32'd1, 1'b0);
      send_item(KIND_DECRYPT, 32'd3232, 1'b0);
      send_item(KIND_ENCRYPT, 32'd3233, 1'b0);
      send_item(KIND_DECRYPT, 32'hFFFF_FFFF, 1'b1);
      wait_for_responses();
   endtask

   // register extremes, degenerate moduli, zero exponents, ignored index
   task automatic test_register_extremes();
      write_key(CSR_UNUSED, 32'hFFFF_FFFF);
      send_item(KIND_ENCRYPT, 32'd123, 1'b1);
      wait_for_responses();
      // zero modulus, then modulus one even with a zero exponent
      write_key(CSR_MODULUS, 32'd0);
      send_item(KIND_ENCRYPT, 32'd5, 1'b0);
      send_item(KIND_DECRYPT, 32'hFFFF_FFFF, 1'b1);
      wait_for_responses();
      write_key(CSR_MODULUS, 32'd1);
      write_key(CSR_PUBLIC_EXP, 32'd0);
      send_item(KIND_ENCRYPT, 32'd7, 1'b1);
      wait_for_responses();
      write_key(CSR_MODULUS, 32'd2);
      send_item(KIND_ENCRYPT, 32'd3, 1'b0);
      send_item(KIND_DECRYPT, 32'd3, 1'b1);
      wait_for_responses();
      // widest modulus, zero and full exponents
      write_key(CSR_MODULUS, 32'hFFFF_FFFF);
      write_key(CSR_PRIVATE_EXP, 32'hFFFF_FFFF);
      send_item(KIND_ENCRYPT, 32'hFFFF_FFFF, 1'b0);
      send_item(KIND_ENCRYPT, 32'd12345, 1'b0);
      send_item(KIND_DECRYPT, 32'hFFFF_FFFE, 1'b1);
      send_item(KIND_DECRYPT, 32'd2, 1'b0);
      wait_for_responses();
      write_key(CSR_MODULUS, 32'hFFFF_FFFB);
      write_key(CSR_PUBLIC_EXP, 32'hFFFF_FFFF);
      write_key(CSR_PRIVATE_EXP, 32'd1);
      send_item(KIND_ENCRYPT, 32'hFFFF_FFFF, 1'b0);
      send_item(KIND_DECRYPT, 32'hFFFF_FFFC, 1'b1);
      send_item(KIND_DECRYPT, 32'hFFFF_FFFB, 1'b0);
      wait_for_responses();
      write_key(CSR_PUBLIC_EXP, 32'd1);
      send_item(KIND_ENCRYPT, 32'd0, 1'b1);
      wait_for_responses();
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_response_hold();
      string text;
      text = "RSA hold";
      write_key(CSR_MODULUS, 32'd3233);
      write_key(CSR_PUBLIC_EXP, 32'd17);
      write_key(CSR_PRIVATE_EXP, 32'd2753);
      gap_max   = 0;
      stall_pct = 0;
      hold_request = HOLD_OFF;
      for (int i = 0; i < text.len(); i++)
         send_item(i[0], {24'b0, text[i]}, i == text.len() - 1);
      req_valid <= 1'b0;
      while (hold_request > 0 || hold_left > 0) @(posedge clock);
      wait_for_responses();
   endtask

   // random keys per phase, messages of random length ending on last
   task automatic test_random_messages();
      int   sent;
      int   len;
      logic kind;
      bit   mixed;
      for (int phase = 0; phase < 8; phase++) begin
         write_key(CSR_MODULUS, pick_modulus());
         write_key(CSR_PUBLIC_EXP, pick_exponent(phase >= 6));
         write_key(CSR_PRIVATE_EXP, pick_exponent(phase >= 6));
         if ($urandom_range(0, 3) == 0) write_key(CSR_UNUSED, $urandom);
         if (phase == 0) begin
            gap_max   = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0:       gap_max = 0;
               1:       gap_max = 3;
               2:       gap_max = 20;
               default: gap_max = 80;
            endcase
            stall_pct = $urandom_range(10, 70);
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len   = $urandom_range(1, 6);
            kind  = 1'($urandom_range(0, 1));
            mixed = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len; k++) begin
               if (mixed) kind = 1'($urandom_range(0, 1));
               send_item(kind, pick_value(key_modulus), k == len - 1);
            end
            sent += len;
         end
         wait_for_responses();
      end
      gap_max   = 0;
      stall_pct = 0;
   endtask

   // receiver: random stall runs, or a long hold-off when a test asks for one
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_pct == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         if (run_left == 0) begin
            run_stall = ($urandom_range(0, 99) < stall_pct);
            run_left  = run_stall ? $urandom_range(1, 40) : $urandom_range(1, 60);
         end
         run_left--;
         rsp_stall <= run_stall;
      end
   end

   // compare each response beat with the oldest owed result
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cipher.size() == 0) begin
            note_failure($sformatf("unexpected beat: value %h last %b",
                                   rsp_data.result_value, rsp_data.result_last));
         end else begin
            want = pending_cipher.pop_front();
            if (rsp_data.result_value !== want.result_value ||
                rsp_data.result_last !== want.result_last)
               note_failure($sformatf("mismatch: expected value %h last %b, got value %h last %b",
                                      want.result_value, want.result_last,
                                      rsp_data.result_value, rsp_data.result_last));
         end
      end
   end

   // watchdog: too long with no beat on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      key_modulus = 32'd3233;
      key_public  = 32'd17;
      key_private = 32'd2753;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_keys();
      test_register_extremes();
      test_response_hold();
      test_random_messages();
      wait_for_responses();
      repeat (END_WAIT) @(posedge clock);
      if (fail_count == 0 && pending_cipher.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
